/* rtl/core/fduart_pkg.sv */
// Shared constants for the full-duplex serial transceiver core.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package fduart_pkg;

   localparam int BYTE_W = 8;
   localparam int BIT_PERIOD_W = 16;

   localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd1250;

   // 8N1 frame: start, eight data bits, stop
   localparam logic [3:0] FRAME_BITS = 4'd10;
   localparam logic [3:0] DATA_BITS = 4'd8;

endpackage

`default_nettype wire

/* rtl/core/fduart_req_if.sv */
// Request channel: one clock tick of line level and host FIFO requests per item.
// Depends on fduart_pkg for the byte width.
`default_nettype none

interface fduart_req_if;
   logic                          valid;
   logic                          ready;
   logic                          rx_line;
   logic                          tx_write;
   logic [fduart_pkg::BYTE_W-1:0] tx_byte;
   logic                          rx_read;

   modport source (output valid, output rx_line, output tx_write, output tx_byte,
                   output rx_read, input ready);
   modport sink (input valid, input rx_line, input tx_write, input tx_byte,
                 input rx_read, output ready);
endinterface

`default_nettype wire

/* rtl/core/fduart_rsp_if.sv */
// Response channel: line and FIFO status after each tick.
// Depends on fduart_pkg for the byte width.
`default_nettype none

interface fduart_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          tx_line;
   logic [fduart_pkg::BYTE_W-1:0] rx_head_byte;
   logic                          rx_available;
   logic                          tx_fifo_full;
   logic                          rx_overflow;
   logic                          tx_busy;

   modport source (output valid, output tx_line, output rx_head_byte,
                   output rx_available, output tx_fifo_full, output rx_overflow,
                   output tx_busy, input ready);
   modport sink (input valid, input tx_line, input rx_head_byte, input rx_available,
                 input tx_fifo_full, input rx_overflow, input tx_busy, output ready);
endinterface

`default_nettype wire

/* rtl/core/fduart_fifo.sv */
// Byte FIFO with show-ahead head register, pointers counting modulo twice the depth.
// Depends on fduart_pkg for the byte width.
`default_nettype none

module fduart_fifo #(
   parameter int DEPTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push_en,
   input  wire logic [fduart_pkg::BYTE_W-1:0]      push_data,
   input  wire logic                               pop_en,
   output logic      [$clog2(DEPTH+1)-1:0]         count,
   output logic      [fduart_pkg::BYTE_W-1:0]      head
);

   localparam int PTR_W  = $clog2(2 * DEPTH);
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(2 * DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
   localparam logic [PTR_W:0]   PTR_WRAP  = (PTR_W + 1)'(2 * DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [SLOT_W-1:0]             wr_slot, rd_slot_in;
   logic [PTR_W:0]                diff;
   logic [fduart_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [fduart_pkg::BYTE_W-1:0] head_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   // fold pointer into a slot: one compare and subtract
   assign wr_slot    = SLOT_W'((wr_ptr_ff >= PTR_DEPTH) ? wr_ptr_ff - PTR_DEPTH : wr_ptr_ff);
   assign rd_slot_in = SLOT_W'((rd_ptr_in >= PTR_DEPTH) ? rd_ptr_in - PTR_DEPTH : rd_ptr_in);

   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) begin
         diff = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
      end else begin
         diff = {1'b0, wr_ptr_ff} + PTR_WRAP - {1'b0, rd_ptr_ff};
      end
   end

   assign count = CNT_W'(diff);
   assign head  = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // keep the head register on the slot the read pointer will point at,
   // forwarding a byte written into that very slot
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[wr_slot] <= push_data;
      end
      if (push_en && (wr_slot == rd_slot_in)) begin
         head_ff <= push_data;
      end else begin
         head_ff <= mem[rd_slot_in];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CNT_FULL)
      else $error("fifo count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_en |-> (count != CNT_FULL || pop_en))
      else $error("push into full fifo");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop_en |-> (count != '0 || push_en))
      else $error("pop from empty fifo");

endmodule

`default_nettype wire

/* rtl/core/full_duplex_uart_with_fifos_core.sv */
// Full-duplex 8N1 serial transceiver with transmit and receive byte FIFOs.
// Depends on fduart_pkg, fduart_req_if, fduart_rsp_if and fduart_fifo.
//
//   channel  | dir | handshake          | carries
//   ---------+-----+--------------------+-------------------------------------------
//   req_ch   | in  | valid/ready        | rx_line, tx_write, tx_byte, rx_read
//   rsp_ch   | out | valid/ready        | tx_line, rx_head_byte, rx_available,
//            |     |                    | tx_fifo_full, rx_overflow, tx_busy
//   csr_*    | in  | csr_wr_en          | bit_period (16 bits)
//
// One item per clock: each item is one tick of both bit timers, and all state
// moves at the edge that accepts it; the response goes on to a free output register.
// The state registers form a result stage in front of the output register, so
// an item is taken while an older response waits; input stalls only when both hold.
// Synchronous reset empties both FIFOs at once (pointer reset, no clearing pass).
`default_nettype none

module full_duplex_uart_with_fifos_core #(
   parameter int FIFO_DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   fduart_req_if.sink                                  req_ch,
   fduart_rsp_if.source                                rsp_ch,
   input  wire logic                                   csr_wr_en,
   input  wire logic [fduart_pkg::BIT_PERIOD_W-1:0]    csr_wr_data
);

   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   // handshake
   logic acc, adv, res_vld_ff, res_vld_in;

   logic [fduart_pkg::BIT_PERIOD_W-1:0] bit_period_ff;

   // transmitter
   logic [CNT_W-1:0]              tx_cnt, tx_cnt_p;
   logic [fduart_pkg::BYTE_W-1:0] tx_head, tx_load_byte;
   logic                          tx_push, tx_load;
   logic [9:0]                    tx_shift_ff, tx_shift_in;
   logic [3:0]                    tx_bits_ff, tx_bits_in;
   logic [15:0]                   tx_timer_ff, tx_timer_in;
   logic                          tx_active_ff, tx_active_in;
   logic                          tx_level_ff, tx_level_in;

   // receiver
   logic [CNT_W-1:0]              rx_cnt;
   logic [fduart_pkg::BYTE_W-1:0] rx_head;
   logic                          rx_rd_ok, rx_full_ap, rx_done, rx_push, rx_pop;
   logic [7:0]                    rx_shift_ff, rx_shift_in;
   logic [3:0]                    rx_bits_ff, rx_bits_in, rx_bits_dec;
   logic [16:0]                   rx_timer_ff, rx_timer_in;
   logic                          rx_recv_ff, rx_recv_in;
   logic                          rx_prev_ff;
   logic                          overflow_ff, overflow_in;

   // output register
   logic                          out_vld_ff;
   logic                          out_tx_line_ff;
   logic [fduart_pkg::BYTE_W-1:0] out_head_ff;
   logic                          out_avail_ff, out_full_ff, out_ovf_ff, out_busy_ff;

   assign acc = req_ch.valid & req_ch.ready;
   assign adv = res_vld_ff & (~out_vld_ff | rsp_ch.ready);
   assign req_ch.ready = ~res_vld_ff | adv;
   assign res_vld_in = acc | (res_vld_ff & ~adv);

   // ---------------- transmitter ----------------
   assign tx_push  = acc & req_ch.tx_write & (tx_cnt != CNT_FULL);
   assign tx_cnt_p = tx_cnt + CNT_W'(tx_push);
   // an empty FIFO before the push means the frame byte is the one just queued
   assign tx_load_byte = (tx_cnt == '0) ? req_ch.tx_byte : tx_head;

   always_comb begin
      tx_shift_in  = tx_shift_ff;
      tx_bits_in   = tx_bits_ff;
      tx_timer_in  = tx_timer_ff;
      tx_active_in = tx_active_ff;
      tx_level_in  = tx_level_ff;
      tx_load      = 1'b0;
      if (!tx_active_ff) begin
         tx_load = (tx_cnt_p != '0);
      end else if (tx_timer_ff <= 16'd1) begin
         tx_timer_in = bit_period_ff;
         if (tx_bits_ff != '0) begin
            tx_level_in = tx_shift_ff[0];
            tx_shift_in = {1'b0, tx_shift_ff[9:1]};
            tx_bits_in  = tx_bits_ff - 4'd1;
         end else if (tx_cnt_p != '0) begin
            tx_load = 1'b1;
         end else begin
            tx_active_in = 1'b0;
            tx_bits_in   = fduart_pkg::FRAME_BITS;
            tx_level_in  = 1'b1;
         end
      end else begin
         tx_timer_in = tx_timer_ff - 16'd1;
      end
      if (tx_load) begin
         // hold mark for one bit time ahead of the start bit
         tx_shift_in  = {1'b1, tx_load_byte, 1'b0};
         tx_bits_in   = fduart_pkg::FRAME_BITS;
         tx_level_in  = 1'b1;
         tx_active_in = 1'b1;
         tx_timer_in  = bit_period_ff;
      end
   end

   fduart_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_tx_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (tx_push),
      .push_data (req_ch.tx_byte),
      .pop_en    (acc & tx_load),
      .count     (tx_cnt),
      .head      (tx_head)
   );

   // ---------------- receiver ----------------
   assign rx_rd_ok   = req_ch.rx_read & (rx_cnt != '0);
   assign rx_pop     = acc & rx_rd_ok;
   assign rx_full_ap = (rx_cnt == CNT_FULL) & ~rx_rd_ok;
   assign rx_bits_dec = (rx_bits_ff != '0) ? rx_bits_ff - 4'd1 : rx_bits_ff;

   always_comb begin
      rx_shift_in = rx_shift_ff;
      rx_bits_in  = rx_bits_ff;
      rx_timer_in = rx_timer_ff;
      rx_recv_in  = rx_recv_ff;
      rx_done     = 1'b0;
      if (!rx_recv_ff) begin
         if (rx_prev_ff && !req_ch.rx_line) begin
            rx_recv_in  = 1'b1;
            rx_bits_in  = fduart_pkg::DATA_BITS;
            // first sample lands mid-bit: one and a half periods out
            rx_timer_in = {1'b0, bit_period_ff} + {2'b00, bit_period_ff[15:1]};
         end
      end else if (rx_timer_ff <= 17'd1) begin
         rx_timer_in = {1'b0, bit_period_ff};
         rx_shift_in = {req_ch.rx_line, rx_shift_ff[7:1]};
         rx_bits_in  = rx_bits_dec;
         if (rx_bits_dec == '0) begin
            rx_done    = 1'b1;
            rx_bits_in = fduart_pkg::DATA_BITS;
            rx_recv_in = 1'b0;
         end
      end else begin
         rx_timer_in = rx_timer_ff - 17'd1;
      end
   end

   assign rx_push     = acc & rx_done & ~rx_full_ap;
   assign overflow_in = rx_done & rx_full_ap;

   fduart_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_rx_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (rx_push),
      .push_data (rx_shift_in),
      .pop_en    (rx_pop),
      .count     (rx_cnt),
      .head      (rx_head)
   );

   // ---------------- state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= fduart_pkg::BIT_PERIOD_RESET;
         res_vld_ff    <= 1'b0;
         tx_shift_ff   <= '0;
         tx_bits_ff    <= fduart_pkg::FRAME_BITS;
         tx_timer_ff   <= '0;
         tx_active_ff  <= 1'b0;
         tx_level_ff   <= 1'b1;
         rx_shift_ff   <= '0;
         rx_bits_ff    <= fduart_pkg::DATA_BITS;
         rx_timer_ff   <= '0;
         rx_recv_ff    <= 1'b0;
         rx_prev_ff    <= 1'b1;
         overflow_ff   <= 1'b0;
      end else begin
         res_vld_ff <= res_vld_in;
         if (csr_wr_en) begin
            bit_period_ff <= csr_wr_data;
         end
         if (acc) begin
            tx_shift_ff  <= tx_shift_in;
            tx_bits_ff   <= tx_bits_in;
            tx_timer_ff  <= tx_timer_in;
            tx_active_ff <= tx_active_in;
            tx_level_ff  <= tx_level_in;
            rx_shift_ff  <= rx_shift_in;
            rx_bits_ff   <= rx_bits_in;
            rx_timer_ff  <= rx_timer_in;
            rx_recv_ff   <= rx_recv_in;
            rx_prev_ff   <= req_ch.rx_line;
            overflow_ff  <= overflow_in;
         end
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_tx_line_ff <= tx_level_ff;
         out_head_ff    <= (rx_cnt != '0) ? rx_head : '0;
         out_avail_ff   <= (rx_cnt != '0);
         out_full_ff    <= (tx_cnt == CNT_FULL);
         out_ovf_ff     <= overflow_ff;
         out_busy_ff    <= tx_active_ff;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.tx_line      = out_tx_line_ff;
   assign rsp_ch.rx_head_byte = out_head_ff;
   assign rsp_ch.rx_available = out_avail_ff;
   assign rsp_ch.tx_fifo_full = out_full_ff;
   assign rsp_ch.rx_overflow  = out_ovf_ff;
   assign rsp_ch.tx_busy      = out_busy_ff;

   a_tx_idle_mark: assert property (@(posedge clock) disable iff (reset)
      !tx_active_ff |-> tx_level_ff)
      else $error("transmit line not at mark while idle");

   a_rx_idle_bits: assert property (@(posedge clock) disable iff (reset)
      !rx_recv_ff |-> (rx_bits_ff == fduart_pkg::DATA_BITS))
      else $error("receive bit count not rearmed");

   a_result_moves: assert property (@(posedge clock) disable iff (reset)
      (res_vld_ff && !out_vld_ff) |=> out_vld_ff)
      else $error("result stage did not advance into empty output register");

   a_ovf_needs_full: assert property (@(posedge clock) disable iff (reset)
      (acc && overflow_in) |-> (rx_cnt == CNT_FULL))
      else $error("receive byte dropped with room in fifo");

endmodule

`default_nettype wire

/* tb/full_duplex_uart_with_fifos_checker.sv */
// Response checker for the serial transceiver core: watches both channels and the
// bit_period port, predicts the status after each tick and compares every response.
// Needs fduart_pkg and both channel interfaces.
module full_duplex_uart_with_fifos_checker #(
   parameter int FIFO_DEPTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   fduart_req_if                                    req_mon,
   fduart_rsp_if                                    rsp_mon,
   input  wire logic                                csr_wr_en,
   input  wire logic [fduart_pkg::BIT_PERIOD_W-1:0] csr_wr_data,
   output int                                       mismatches,
   output int                                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PTR_W = $clog2(FIFO_DEPTH) + 1;
   localparam int SLOT_W = PTR_W - 1;

   typedef struct packed {
      logic                          tx_line;
      logic [fduart_pkg::BYTE_W-1:0] rx_head_byte;
      logic                          rx_available;
      logic                          tx_fifo_full;
      logic                          rx_overflow;
      logic                          tx_busy;
   } line_status_type;

   line_status_type status_q[$];
   int              err_total = 0;

   logic [fduart_pkg::BIT_PERIOD_W-1:0] period;

   logic [fduart_pkg::BYTE_W-1:0] tx_mem [FIFO_DEPTH];
   logic [fduart_pkg::BYTE_W-1:0] rx_mem [FIFO_DEPTH];
   logic [PTR_W-1:0]              tx_wp, tx_rp, rx_wp, rx_rp;

   logic [9:0]                          tx_frame;
   logic [3:0]                          tx_left;
   logic [fduart_pkg::BIT_PERIOD_W-1:0] tx_tmr;
   logic                                tx_on, tx_pin;

   logic [fduart_pkg::BYTE_W-1:0] rx_frame;
   logic [3:0]                    rx_left;
   logic [16:0]                   rx_tmr;
   logic                          rx_on, rx_last;

   initial begin
      mismatches = 0;
      pending = 0;
   end

   function automatic logic [PTR_W-1:0] fill(input logic [PTR_W-1:0] wp,
                                             input logic [PTR_W-1:0] rp);
      return wp - rp;
   endfunction

   task automatic clear_state();
      period = fduart_pkg::BIT_PERIOD_RESET;
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         tx_mem[i] = '0;
         rx_mem[i] = '0;
      end
      tx_wp = '0;
      tx_rp = '0;
      rx_wp = '0;
      rx_rp = '0;
      tx_frame = '0;
      tx_left = fduart_pkg::FRAME_BITS;
      tx_tmr = '0;
      tx_on = 1'b0;
      tx_pin = 1'b1;
      rx_frame = '0;
      rx_left = fduart_pkg::DATA_BITS;
      rx_tmr = '0;
      rx_on = 1'b0;
      rx_last = 1'b1;
   endtask

   task automatic load_tx_frame();
      logic [fduart_pkg::BYTE_W-1:0] b;
      b = tx_mem[tx_rp[SLOT_W-1:0]];
      tx_rp = tx_rp + 1'b1;
      // stop bit on top, start bit at the bottom, data LSB first
      tx_frame = {1'b1, b, 1'b0};
      tx_left = fduart_pkg::FRAME_BITS;
      tx_pin = 1'b1;
      tx_on = 1'b1;
      tx_tmr = period;
   endtask

   // One clock tick of the transceiver: push, pop, transmitter, receiver.
   task automatic advance_tick(input logic rx_line, input logic tx_write,
                               input logic [fduart_pkg::BYTE_W-1:0] tx_byte,
                               input logic rx_read, output line_status_type st);
      logic ovf;
      ovf = 1'b0;

      if (tx_write && fill(tx_wp, tx_rp) < FIFO_DEPTH) begin
         tx_mem[tx_wp[SLOT_W-1:0]] = tx_byte;
         tx_wp = tx_wp + 1'b1;
      end
      if (rx_read && fill(rx_wp, rx_rp) != 0)
         rx_rp = rx_rp + 1'b1;

      if (!tx_on) begin
         if (fill(tx_wp, tx_rp) != 0)
            load_tx_frame();
      end else if (tx_tmr <= 1) begin
         tx_tmr = period;
         if (tx_left != 0) begin
            tx_pin = tx_frame[0];
            tx_frame = tx_frame >> 1;
            tx_left = tx_left - 1'b1;
         end else if (fill(tx_wp, tx_rp) != 0) begin
            load_tx_frame();
         end else begin
            tx_on = 1'b0;
            tx_left = fduart_pkg::FRAME_BITS;
            tx_pin = 1'b1;
         end
      end else begin
         tx_tmr = tx_tmr - 1'b1;
      end

      if (!rx_on) begin
         // falling edge on an idle line: wait a bit and a half for data bit 0
         if (rx_last && !rx_line) begin
            rx_on = 1'b1;
            rx_left = fduart_pkg::DATA_BITS;
            rx_tmr = 17'(period) + 17'(period >> 1);
         end
      end else if (rx_tmr <= 1) begin
         rx_tmr = 17'(period);
         rx_frame = {rx_line, rx_frame[fduart_pkg::BYTE_W-1:1]};
         if (rx_left != 0)
            rx_left = rx_left - 1'b1;
         if (rx_left == 0) begin
            if (fill(rx_wp, rx_rp) < FIFO_DEPTH) begin
               rx_mem[rx_wp[SLOT_W-1:0]] = rx_frame;
               rx_wp = rx_wp + 1'b1;
            end else begin
               ovf = 1'b1;
            end
            rx_left = fduart_pkg::DATA_BITS;
            rx_on = 1'b0;
         end
      end else begin
         rx_tmr = rx_tmr - 1'b1;
      end
      rx_last = rx_line;

      st.tx_line = tx_pin;
      st.rx_available = (fill(rx_wp, rx_rp) != 0);
      st.rx_head_byte = st.rx_available ? rx_mem[rx_rp[SLOT_W-1:0]] : '0;
      st.tx_fifo_full = (fill(tx_wp, tx_rp) >= FIFO_DEPTH);
      st.rx_overflow = ovf;
      st.tx_busy = tx_on;
   endtask

   function automatic int field_bad(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      line_status_type want, got;
      if (reset) begin
         clear_state();
         status_q.delete();
      end else begin
         if (csr_wr_en)
            period = csr_wr_data;

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_q.size() == 0) begin
               $error("response with no item outstanding");
               err_total++;
            end else begin
               want = status_q.pop_front();
               got.tx_line = rsp_mon.tx_line;
               got.rx_head_byte = rsp_mon.rx_head_byte;
               got.rx_available = rsp_mon.rx_available;
               got.tx_fifo_full = rsp_mon.tx_fifo_full;
               got.rx_overflow = rsp_mon.rx_overflow;
               got.tx_busy = rsp_mon.tx_busy;
               err_total += field_bad("tx_line", 8'(want.tx_line), 8'(got.tx_line));
               err_total += field_bad("rx_head_byte", want.rx_head_byte, got.rx_head_byte);
               err_total += field_bad("rx_available", 8'(want.rx_available),
                                      8'(got.rx_available));
               err_total += field_bad("tx_fifo_full", 8'(want.tx_fifo_full),
                                      8'(got.tx_fifo_full));
               err_total += field_bad("rx_overflow", 8'(want.rx_overflow),
                                      8'(got.rx_overflow));
               err_total += field_bad("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            advance_tick(req_mon.rx_line, req_mon.tx_write, req_mon.tx_byte,
                         req_mon.rx_read, want);
            status_q.push_back(want);
         end
      end
      mismatches <= err_total;
      pending <= status_q.size();
   end

endmodule

/* tb/full_duplex_uart_with_fifos_core_tb.sv */
// Top of the transceiver testbench: clock, reset, tick stimulus with serial frames on
// the receive line, bit_period writes, a stalling response sink and the verdict.
// Needs the core, its package and interfaces, and full_duplex_uart_with_fifos_checker.
module full_duplex_uart_with_fifos_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD = 10;
   localparam int FIFO_DEPTH = 32;
   localparam int NUM_PHASES = 4;
   localparam int PHASE_ITEMS = 110;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 8;
   localparam int SETTLE_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [fduart_pkg::BIT_PERIOD_W-1:0] csr_wr_data;

   fduart_req_if req_ch ();
   fduart_rsp_if rsp_ch ();

   int mismatches;
   int pending;

   // per-phase knobs: percent idle on each side, per-mille write and pop rates
   int phase_idle[NUM_PHASES] = '{0, 83, 0, 38};
   int phase_stall[NUM_PHASES] = '{0, 0, 83, 38};
   int phase_wr_pm[NUM_PHASES] = '{200, 0, 0, 6};
   int phase_rd_pm[NUM_PHASES] = '{0, 0, 2, 150};

   int idle_pct = 0;
   int stall_pct = 0;
   int wr_pm = 0;
   int rd_pm = 0;
   int cur_period = 16;
   int sent_items = 0;

   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   full_duplex_uart_with_fifos_core #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   full_duplex_uart_with_fifos_checker #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_mon(req_ch),
      .rsp_mon(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatches(mismatches),
      .pending(pending)
   );

   // Response sink: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // Offer one tick and hold it until accepted.
   task automatic offer_tick(input logic rx, input logic wr,
                             input logic [fduart_pkg::BYTE_W-1:0] b, input logic rd);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_line <= rx;
      req_ch.tx_write <= wr;
      req_ch.tx_byte <= b;
      req_ch.rx_read <= rd;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      sent_items++;
   endtask

   task automatic random_tick(input logic rx);
      offer_tick(rx, $urandom_range(999) < wr_pm, 8'($urandom_range(255)),
                 $urandom_range(999) < rd_pm);
   endtask

   // Drive the first nbits of an 8N1 frame, each bit_len ticks long, then a mark gap.
   task automatic drive_serial_frame(input logic [7:0] data, input int bit_len,
                                     input int nbits);
      logic [9:0] frame;
      frame = {1'b1, data, 1'b0};
      for (int i = 0; i < nbits; i++)
         repeat (bit_len) random_tick(frame[i]);
      repeat ($urandom_range(cur_period)) random_tick(1'b1);
   endtask

   // Drain all responses, let the pipe settle, then write bit_period.
   task automatic set_bit_period(input int value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= fduart_pkg::BIT_PERIOD_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_period = value;
   endtask

   initial begin
      int pick;
      req_ch.valid = 1'b0;
      req_ch.rx_line = 1'b1;
      req_ch.tx_write = 1'b0;
      req_ch.tx_byte = '0;
      req_ch.rx_read = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = fduart_pkg::BIT_PERIOD_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_bit_period(16);

      // pop on empty, first frame start, byte extremes, edge while receiving
      offer_tick(1'b1, 1'b0, 8'h00, 1'b1);
      offer_tick(1'b1, 1'b1, 8'h00, 1'b0);
      offer_tick(1'b1, 1'b1, 8'hFF, 1'b1);
      offer_tick(1'b0, 1'b1, 8'h5A, 1'b1);
      offer_tick(1'b1, 1'b0, 8'hA5, 1'b0);
      offer_tick(1'b0, 1'b0, 8'h00, 1'b0);
      offer_tick(1'b1, 1'b1, 8'h80, 1'b0);
      offer_tick(1'b0, 1'b0, 8'h01, 1'b1);
      repeat (8) offer_tick(1'b1, 1'b0, 8'hFF, 1'b0);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: set_bit_period(16);
            1: set_bit_period($urandom_range(16, 24));
            2: set_bit_period(17);
            default: set_bit_period($urandom_range(16, 32));
         endcase
         idle_pct = phase_idle[ph];
         stall_pct <= phase_stall[ph];
         wr_pm = phase_wr_pm[ph];
         rd_pm = phase_rd_pm[ph];
         // hold the sink off while the sender keeps pushing ticks
         if (ph == 0)
            hold_token <= hold_token + 1;
         while (sent_items < (ph + 1) * PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 75)
               drive_serial_frame(8'($urandom_range(255)), cur_period, 10);
            else if (pick < 88)
               drive_serial_frame(8'($urandom_range(255)),
                                  cur_period - 3 + $urandom_range(6), $urandom_range(1, 10));
            else
               repeat ($urandom_range(1, 20)) random_tick(1'($urandom_range(1)));
         end
      end

      // longest bit time: only the timer loads and the first ticks are reachable
      set_bit_period(65535);
      wr_pm = 500;
      rd_pm = 500;
      repeat (20) random_tick(1'($urandom_range(1)));

      req_ch.valid <= 1'b0;
      stall_pct <= 0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
